@@ rtl/core/ufcd_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ufcd_pkg: shared types and constants for the union-find cycle detector
// Control word layout, step addresses of the control program, condition
// codes and the status bundle that the datapath returns to the sequencer.
// ----------------------------------------------------------------------------
package ufcd_pkg;

  localparam int RANK_W = 4;
  localparam logic [RANK_W-1:0] RANK_MAX = 4'd15;
  localparam int NODE_W = 10;
  localparam int COUNT_W = 11;
  localparam logic [COUNT_W-1:0] NODE_COUNT_RESET = 11'd1024;
  localparam int UPC_W = 5;

  localparam logic OPC_ADD = 1'b0;
  localparam logic OPC_CLEAR = 1'b1;

  // Step addresses of the control program.
  localparam logic [UPC_W-1:0] STEP_INIT     = 5'd0;
  localparam logic [UPC_W-1:0] STEP_IDLE     = 5'd1;
  localparam logic [UPC_W-1:0] STEP_DISPATCH = 5'd2;
  localparam logic [UPC_W-1:0] STEP_START_A  = 5'd3;
  localparam logic [UPC_W-1:0] STEP_WALK_RD  = 5'd4;
  localparam logic [UPC_W-1:0] STEP_WALK     = 5'd5;
  localparam logic [UPC_W-1:0] STEP_COMP_CHK = 5'd6;
  localparam logic [UPC_W-1:0] STEP_COMPRESS = 5'd7;
  localparam logic [UPC_W-1:0] STEP_FIND_END = 5'd8;
  localparam logic [UPC_W-1:0] STEP_LOAD_B   = 5'd9;
  localparam logic [UPC_W-1:0] STEP_UNION    = 5'd10;
  localparam logic [UPC_W-1:0] STEP_LINK     = 5'd11;
  localparam logic [UPC_W-1:0] STEP_BUMP     = 5'd12;
  localparam logic [UPC_W-1:0] STEP_CYCLE    = 5'd13;
  localparam logic [UPC_W-1:0] STEP_CLEAR    = 5'd14;
  localparam logic [UPC_W-1:0] STEP_FINISH   = 5'd15;
  localparam logic [UPC_W-1:0] STEP_FIN_WAIT = 5'd16;

  typedef enum logic [3:0] {
    C_NEVER,
    C_ALWAYS,
    C_NO_FIRE,
    C_IS_CLEAR,
    C_OOR,
    C_PARENT_MOVES,
    C_CUR_IS_ROOT,
    C_SIDE_B,
    C_SAME_ROOT,
    C_NOT_TIE,
    C_CLR_MORE,
    C_OUT_FREE
  } cond_t;

  typedef enum logic [1:0] {
    RD_WALK,
    RD_CUR,
    RD_PARENT
  } rd_sel_t;

  typedef enum logic [2:0] {
    WR_NONE,
    WR_COMPRESS,
    WR_LINK,
    WR_BUMP,
    WR_CLEAR
  } wr_op_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD_ITEM,
    OP_START_A,
    OP_WALK,
    OP_COMPRESS,
    OP_LOAD_B,
    OP_SET_CYCLE,
    OP_CLEAR_STEP,
    OP_RESULT
  } dp_op_t;

  typedef struct packed {
    logic             accept;
    rd_sel_t          rd_sel;
    wr_op_t           wr_op;
    dp_op_t           dp_op;
    cond_t            cond;
    logic [UPC_W-1:0] target;
  } ctrl_t;

  typedef struct packed {
    logic fire;
    logic is_clear;
    logic oor;
    logic parent_moves;
    logic cur_is_root;
    logic side_b;
    logic same_root;
    logic rank_tie;
    logic clr_more;
    logic out_free;
  } status_t;

  function automatic ctrl_t uword(input logic accept, input rd_sel_t rd_sel,
                                  input wr_op_t wr_op, input dp_op_t dp_op,
                                  input cond_t cond, input logic [UPC_W-1:0] target);
    ctrl_t w;
    w.accept = accept;
    w.rd_sel = rd_sel;
    w.wr_op  = wr_op;
    w.dp_op  = dp_op;
    w.cond   = cond;
    w.target = target;
    return w;
  endfunction

endpackage

@@ rtl/core/union_find_cycle_detect.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// union_find_cycle_detect: cycle detection on a stream of undirected edges
// Disjoint-set forest with path compression and union by rank, run by a
// small microcoded sequencer over a single forest memory.
// ----------------------------------------------------------------------------
// The block takes one word at a time on the input channel and returns one
// result word for each. An add word finds the roots of both nodes, points
// every node on both find paths straight at its root, and then either flags
// a cycle (same root) or joins the two roots by rank. A clear word rewrites
// the whole forest memory to the identity with zero ranks and drops the
// sticky cycle flag. All forest work goes through one memory with one write
// and one registered read per cycle, so the memory port sets the pace: an
// add word takes longer for each parent hop walked, for each node
// re-pointed and when the two roots tie on rank; an add word with an
// out-of-range node skips both finds; a clear word writes all MAX_NODES
// forest entries in turn.
// After reset a clearing pass over the whole forest runs before the first
// word is accepted. A finished result waits in the output register, so the
// next word can be accepted while it is unread.
// node_count may be written at any idle time and does not touch the forest.
// ----------------------------------------------------------------------------
module union_find_cycle_detect #(
  parameter int MAX_NODES = 1024
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_write,
  input  logic [ufcd_pkg::COUNT_W-1:0] cfg_data,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         opcode,
  input  logic [ufcd_pkg::NODE_W-1:0]  first_node,
  input  logic [ufcd_pkg::NODE_W-1:0]  second_node,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         closes_cycle,
  output logic                         cycle_seen,
  output logic                         node_out_of_range
);
  import ufcd_pkg::*;

  ctrl_t   ctrl;
  status_t status;

  // The sequencer steps through the control program; the datapath carries
  // out each control word and reports the branch conditions back.
  ufcd_sequencer u_seq (
    .clk    (clk),
    .rst    (rst),
    .status (status),
    .ctrl   (ctrl)
  );

  ufcd_datapath #(
    .MAX_NODES (MAX_NODES)
  ) u_dp (
    .clk               (clk),
    .rst               (rst),
    .cfg_write         (cfg_write),
    .cfg_data          (cfg_data),
    .in_valid          (in_valid),
    .opcode            (opcode),
    .first_node        (first_node),
    .second_node       (second_node),
    .out_ready         (out_ready),
    .out_valid         (out_valid),
    .closes_cycle      (closes_cycle),
    .cycle_seen        (cycle_seen),
    .node_out_of_range (node_out_of_range),
    .ctrl              (ctrl),
    .status            (status)
  );

  // Only the idle step of the program takes a word.
  assign in_ready = ctrl.accept;

  // One word at a time: the step after an acceptance never accepts.
  assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted on two consecutive cycles");

  // A closed cycle always leaves the sticky flag set in the same result.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && closes_cycle |-> cycle_seen)
    else $error("cycle closed without sticky flag");

  // An ignored edge can never close a cycle.
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(closes_cycle && node_out_of_range))
    else $error("out-of-range edge reported as closing a cycle");

  // A forest write only happens while no word is being accepted.
  assert property (@(posedge clk) disable iff (rst)
    in_ready |-> ctrl.wr_op == WR_NONE)
    else $error("forest written in the idle step");

endmodule

@@ rtl/core/ufcd_ucode_rom.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ufcd_ucode_rom: control store of the union-find sequencer
// One control word per step: input handshake, forest read and write
// selects, datapath operation, branch condition and branch target.
// ----------------------------------------------------------------------------
module ufcd_ucode_rom (
  input  logic [ufcd_pkg::UPC_W-1:0] upc,
  output ufcd_pkg::ctrl_t            word
);
  import ufcd_pkg::*;

  always_comb begin
    unique case (upc)
      STEP_INIT:     word = uword(1'b0, RD_WALK, WR_CLEAR, OP_CLEAR_STEP, C_CLR_MORE, STEP_INIT);
      STEP_IDLE:     word = uword(1'b1, RD_WALK, WR_NONE, OP_LOAD_ITEM, C_NO_FIRE, STEP_IDLE);
      STEP_DISPATCH: word = uword(1'b0, RD_WALK, WR_NONE, OP_NONE, C_IS_CLEAR, STEP_CLEAR);
      STEP_START_A:  word = uword(1'b0, RD_WALK, WR_NONE, OP_START_A, C_OOR, STEP_FINISH);
      STEP_WALK_RD:  word = uword(1'b0, RD_WALK, WR_NONE, OP_NONE, C_NEVER, STEP_IDLE);
      STEP_WALK:     word = uword(1'b0, RD_PARENT, WR_NONE, OP_WALK, C_PARENT_MOVES, STEP_WALK);
      STEP_COMP_CHK: word = uword(1'b0, RD_CUR, WR_NONE, OP_NONE, C_CUR_IS_ROOT, STEP_FIND_END);
      STEP_COMPRESS: word = uword(1'b0, RD_PARENT, WR_COMPRESS, OP_COMPRESS, C_PARENT_MOVES,
                                  STEP_COMPRESS);
      STEP_FIND_END: word = uword(1'b0, RD_WALK, WR_NONE, OP_NONE, C_SIDE_B, STEP_UNION);
      STEP_LOAD_B:   word = uword(1'b0, RD_WALK, WR_NONE, OP_LOAD_B, C_ALWAYS, STEP_WALK_RD);
      STEP_UNION:    word = uword(1'b0, RD_WALK, WR_NONE, OP_NONE, C_SAME_ROOT, STEP_CYCLE);
      STEP_LINK:     word = uword(1'b0, RD_WALK, WR_LINK, OP_NONE, C_NOT_TIE, STEP_FINISH);
      STEP_BUMP:     word = uword(1'b0, RD_WALK, WR_BUMP, OP_NONE, C_ALWAYS, STEP_FINISH);
      STEP_CYCLE:    word = uword(1'b0, RD_WALK, WR_NONE, OP_SET_CYCLE, C_ALWAYS, STEP_FINISH);
      STEP_CLEAR:    word = uword(1'b0, RD_WALK, WR_CLEAR, OP_CLEAR_STEP, C_CLR_MORE, STEP_CLEAR);
      STEP_FINISH:   word = uword(1'b0, RD_WALK, WR_NONE, OP_RESULT, C_OUT_FREE, STEP_IDLE);
      STEP_FIN_WAIT: word = uword(1'b0, RD_WALK, WR_NONE, OP_NONE, C_ALWAYS, STEP_FINISH);
      default:       word = uword(1'b0, RD_WALK, WR_NONE, OP_NONE, C_ALWAYS, STEP_IDLE);
    endcase
  end

endmodule

@@ rtl/core/ufcd_sequencer.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ufcd_sequencer: step counter and branch logic
// Holds the step counter, evaluates the branch condition of the current
// control word against datapath status and picks the next step.
// ----------------------------------------------------------------------------
module ufcd_sequencer (
  input  logic              clk,
  input  logic              rst,
  input  ufcd_pkg::status_t status,
  output ufcd_pkg::ctrl_t   ctrl
);
  import ufcd_pkg::*;

  logic [UPC_W-1:0] upc;
  logic [UPC_W-1:0] upc_next;
  logic             cond_met;

  ufcd_ucode_rom u_rom (
    .upc  (upc),
    .word (ctrl)
  );

  always_comb begin
    unique case (ctrl.cond)
      C_NEVER:        cond_met = 1'b0;
      C_ALWAYS:       cond_met = 1'b1;
      C_NO_FIRE:      cond_met = !status.fire;
      C_IS_CLEAR:     cond_met = status.is_clear;
      C_OOR:          cond_met = status.oor;
      C_PARENT_MOVES: cond_met = status.parent_moves;
      C_CUR_IS_ROOT:  cond_met = status.cur_is_root;
      C_SIDE_B:       cond_met = status.side_b;
      C_SAME_ROOT:    cond_met = status.same_root;
      C_NOT_TIE:      cond_met = !status.rank_tie;
      C_CLR_MORE:     cond_met = status.clr_more;
      C_OUT_FREE:     cond_met = status.out_free;
      default:        cond_met = 1'b0;
    endcase
    upc_next = cond_met ? ctrl.target : upc + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      upc <= STEP_INIT;
    end else begin
      upc <= upc_next;
    end
  end

endmodule

@@ rtl/core/ufcd_datapath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ufcd_datapath: forest memory and working registers
// One memory word per node holds rank and parent pointer. Registers hold
// the current word, walk and compression pointers, the first root and the
// result register toward the output channel.
// ----------------------------------------------------------------------------
module ufcd_datapath #(
  parameter int MAX_NODES = 1024
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_write,
  input  logic [ufcd_pkg::COUNT_W-1:0]   cfg_data,
  input  logic                           in_valid,
  input  logic                           opcode,
  input  logic [ufcd_pkg::NODE_W-1:0]    first_node,
  input  logic [ufcd_pkg::NODE_W-1:0]    second_node,
  input  logic                           out_ready,
  output logic                           out_valid,
  output logic                           closes_cycle,
  output logic                           cycle_seen,
  output logic                           node_out_of_range,
  input  ufcd_pkg::ctrl_t                ctrl,
  output ufcd_pkg::status_t              status
);
  import ufcd_pkg::*;

  localparam int NW = $clog2(MAX_NODES);
  localparam logic [NW-1:0] LAST_NODE = NW'(MAX_NODES - 1);

  typedef struct packed {
    logic [RANK_W-1:0] rank;
    logic [NW-1:0]     parent;
  } entry_t;

  entry_t forest [MAX_NODES];

  logic [COUNT_W-1:0] node_count;
  logic [NW-1:0]      node_a;
  logic [NW-1:0]      node_b;
  logic [NW-1:0]      walk;
  logic [NW-1:0]      cur;
  logic [NW-1:0]      root_a;
  logic [NW-1:0]      clr_cnt;
  logic [RANK_W-1:0]  rank_cur;
  logic [RANK_W-1:0]  rank_a;
  logic               is_clear;
  logic               oor;
  logic               closes;
  logic               side;
  logic               cycle_flag;
  entry_t             rd;

  logic               fire;
  logic               a_ok;
  logic               b_ok;
  logic               out_free;
  logic               a_higher;
  logic [RANK_W-1:0]  rank_inc;
  logic [NW-1:0]      rd_addr;
  logic               wr_en;
  logic [NW-1:0]      wr_addr;
  entry_t             wr_data;

  assign fire     = in_valid && ctrl.accept;
  assign a_ok     = ({1'b0, first_node} < node_count) && (32'(first_node) < MAX_NODES);
  assign b_ok     = ({1'b0, second_node} < node_count) && (32'(second_node) < MAX_NODES);
  assign out_free = !out_valid || out_ready;
  assign a_higher = rank_a > rank_cur;
  assign rank_inc = (rank_cur == RANK_MAX) ? RANK_MAX : RANK_W'(rank_cur + 1'b1);

  always_comb begin
    case (ctrl.rd_sel)
      RD_CUR:    rd_addr = cur;
      RD_PARENT: rd_addr = rd.parent;
      default:   rd_addr = walk;
    endcase
  end

  // The second root sits in walk after the second find; its rank in rank_cur.
  always_comb begin
    wr_en   = 1'b1;
    wr_addr = walk;
    wr_data = '{rank: rank_inc, parent: walk};
    unique case (ctrl.wr_op)
      WR_NONE: begin
        wr_en = 1'b0;
      end
      WR_COMPRESS: begin
        wr_addr = cur;
        wr_data = '{rank: rd.rank, parent: walk};
      end
      WR_LINK: begin
        wr_addr = a_higher ? walk : root_a;
        wr_data = a_higher ? entry_t'{rank: rank_cur, parent: root_a}
                           : entry_t'{rank: rank_a, parent: walk};
      end
      WR_BUMP: begin
        wr_addr = walk;
      end
      WR_CLEAR: begin
        wr_addr = clr_cnt;
        wr_data = '{rank: '0, parent: clr_cnt};
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      forest[wr_addr] <= wr_data;
    end
    rd <= forest[rd_addr];
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      node_count <= NODE_COUNT_RESET;
      clr_cnt    <= '0;
      cycle_flag <= 1'b0;
      out_valid  <= 1'b0;
      side       <= 1'b0;
    end else begin
      if (cfg_write) begin
        node_count <= cfg_data;
      end
      if (ctrl.dp_op == OP_RESULT && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (ctrl.dp_op)
        OP_START_A:    side <= 1'b0;
        OP_LOAD_B:     side <= 1'b1;
        OP_SET_CYCLE:  cycle_flag <= 1'b1;
        OP_CLEAR_STEP: begin
          clr_cnt    <= (clr_cnt == LAST_NODE) ? '0 : clr_cnt + 1'b1;
          cycle_flag <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  // Working and result registers.
  always_ff @(posedge clk) begin
    case (ctrl.dp_op)
      OP_LOAD_ITEM: begin
        if (fire) begin
          is_clear <= (opcode == OPC_CLEAR);
          oor      <= (opcode == OPC_ADD) && !(a_ok && b_ok);
          closes   <= 1'b0;
          node_a   <= NW'(first_node);
          node_b   <= NW'(second_node);
        end
      end
      OP_START_A: begin
        walk <= node_a;
        cur  <= node_a;
      end
      OP_WALK: begin
        walk     <= rd.parent;
        rank_cur <= rd.rank;
      end
      OP_COMPRESS: begin
        cur <= rd.parent;
      end
      OP_LOAD_B: begin
        root_a <= walk;
        rank_a <= rank_cur;
        walk   <= node_b;
        cur    <= node_b;
      end
      OP_SET_CYCLE: begin
        closes <= 1'b1;
      end
      OP_RESULT: begin
        if (out_free) begin
          closes_cycle      <= closes;
          cycle_seen        <= cycle_flag;
          node_out_of_range <= oor;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    status.fire         = fire;
    status.is_clear     = is_clear;
    status.oor          = oor;
    status.parent_moves = rd.parent != walk;
    status.cur_is_root  = cur == walk;
    status.side_b       = side;
    status.same_root    = walk == root_a;
    status.rank_tie     = rank_a == rank_cur;
    status.clr_more     = clr_cnt != LAST_NODE;
    status.out_free     = out_free;
  end

endmodule
